[design/bpfm_pkg.sv]
// Package for the buffer pool frame manager.
// Word types, command/kind/status codes, cell ops and controller states.
// Used by every module under design/.
package bpfm_pkg;

   localparam int DEF_NUM_FRAMES = 16;
   localparam int DEF_STAMP_BITS = 32;
   localparam int DEF_PIN_BITS   = 8;

   localparam logic [2:0] CMD_FETCH = 3'd0;
   localparam logic [2:0] CMD_UNPIN = 3'd1;
   localparam logic [2:0] CMD_DIRTY = 3'd2;
   localparam logic [2:0] CMD_FLUSH = 3'd3;
   localparam logic [2:0] CMD_INVAL = 3'd4;
   localparam logic [2:0] CMD_FLALL = 3'd5;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_WB     = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_NOTFOUND = 2'd1;
   localparam logic [1:0] STS_NOFREE   = 2'd2;
   localparam logic [1:0] STS_PINZERO  = 2'd3;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] table_id;
      logic [31:0] page_id;
      logic        dirty_flag;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [3:0]  frame_no;
      logic [15:0] io_table_id;
      logic [31:0] io_page_id;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic found;
      logic free_found;
      logic vic_found;
   } carry_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_HIT,
      OP_UNPIN,
      OP_DIRTY,
      OP_CLEAN,
      OP_INSTALL,
      OP_INVAL
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_WB,
      ST_RD,
      ST_WALK,
      ST_STAT
   } state_type;

endpackage

[design/bpfm_cell.sv]
// One frame of the buffer pool: frame state plus a registered search carry
// handed to the next cell. Depends on bpfm_pkg.
module bpfm_cell
   import bpfm_pkg::*;
#(
   parameter int NUM_FRAMES = DEF_NUM_FRAMES,
   parameter int STAMP_BITS = DEF_STAMP_BITS,
   parameter int PIN_BITS   = DEF_PIN_BITS,
   parameter int CELL_IDX   = 0,
   localparam int IDX_W     = $clog2(NUM_FRAMES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           look_table,
   input  logic [31:0]           look_page,
   input  carry_type             carry_i,
   input  logic [IDX_W-1:0]      found_idx_i,
   input  logic [IDX_W-1:0]      free_idx_i,
   input  logic [IDX_W-1:0]      vic_idx_i,
   input  logic [STAMP_BITS-1:0] vic_stamp_i,
   output carry_type             carry_o,
   output logic [IDX_W-1:0]      found_idx_o,
   output logic [IDX_W-1:0]      free_idx_o,
   output logic [IDX_W-1:0]      vic_idx_o,
   output logic [STAMP_BITS-1:0] vic_stamp_o,
   input  op_type                op,
   input  logic [IDX_W-1:0]      op_idx,
   input  logic                  op_dflag,
   input  logic [STAMP_BITS-1:0] op_stamp,
   output logic                  valid_o,
   output logic                  dirty_o,
   output logic [PIN_BITS-1:0]   pins_o,
   output logic [15:0]           table_o,
   output logic [31:0]           page_o
);

   localparam logic [IDX_W-1:0]    MY_IDX  = IDX_W'(CELL_IDX);
   localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

   logic                  valid_ff, valid_in;
   logic                  dirty_ff, dirty_in;
   logic [PIN_BITS-1:0]   pins_ff, pins_in;
   logic [15:0]           table_ff, table_in;
   logic [31:0]           page_ff, page_in;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;

   carry_type             carry_ff, carry_in;
   logic [IDX_W-1:0]      found_idx_ff, found_idx_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]      vic_idx_ff, vic_idx_in;
   logic [STAMP_BITS-1:0] vic_stamp_ff, vic_stamp_in;

   logic match, take_vic, sel;

   always_comb begin
      match    = valid_ff && (table_ff == look_table) && (page_ff == look_page);
      take_vic = (pins_ff == '0) && (!carry_i.vic_found || (stamp_ff < vic_stamp_i));

      carry_in.found      = carry_i.found || match;
      found_idx_in        = carry_i.found ? found_idx_i : MY_IDX;
      carry_in.free_found = carry_i.free_found || !valid_ff;
      free_idx_in         = carry_i.free_found ? free_idx_i : MY_IDX;
      carry_in.vic_found  = carry_i.vic_found || take_vic;
      vic_idx_in          = take_vic ? MY_IDX : vic_idx_i;
      vic_stamp_in        = take_vic ? stamp_ff : vic_stamp_i;
   end

   always_comb begin
      sel      = (op_idx == MY_IDX);
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      pins_in  = pins_ff;
      table_in = table_ff;
      page_in  = page_ff;
      stamp_in = stamp_ff;
      if (sel) begin
         case (op)
            OP_HIT: begin
               if (pins_ff != PIN_MAX) pins_in = pins_ff + 1'b1;
               stamp_in = op_stamp;
            end
            OP_UNPIN: begin
               pins_in  = pins_ff - 1'b1;
               dirty_in = dirty_ff || op_dflag;
               stamp_in = op_stamp;
            end
            OP_DIRTY: begin
               dirty_in = 1'b1;
               stamp_in = op_stamp;
            end
            OP_CLEAN: dirty_in = 1'b0;
            OP_INSTALL: begin
               valid_in = 1'b1;
               dirty_in = 1'b0;
               pins_in  = PIN_BITS'(1);
               table_in = look_table;
               page_in  = look_page;
               stamp_in = op_stamp;
            end
            OP_INVAL: begin
               valid_in = 1'b0;
               dirty_in = 1'b0;
               pins_in  = '0;
               table_in = '0;
               page_in  = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         dirty_ff     <= 1'b0;
         pins_ff      <= '0;
         table_ff     <= '0;
         page_ff      <= '0;
         stamp_ff     <= '0;
         carry_ff     <= '0;
         found_idx_ff <= '0;
         free_idx_ff  <= '0;
         vic_idx_ff   <= '0;
         vic_stamp_ff <= '0;
      end else begin
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         pins_ff      <= pins_in;
         table_ff     <= table_in;
         page_ff      <= page_in;
         stamp_ff     <= stamp_in;
         carry_ff     <= carry_in;
         found_idx_ff <= found_idx_in;
         free_idx_ff  <= free_idx_in;
         vic_idx_ff   <= vic_idx_in;
         vic_stamp_ff <= vic_stamp_in;
      end
   end

   assign carry_o     = carry_ff;
   assign found_idx_o = found_idx_ff;
   assign free_idx_o  = free_idx_ff;
   assign vic_idx_o   = vic_idx_ff;
   assign vic_stamp_o = vic_stamp_ff;
   assign valid_o     = valid_ff;
   assign dirty_o     = dirty_ff;
   assign pins_o      = pins_ff;
   assign table_o     = table_ff;
   assign page_o      = page_ff;

endmodule

[design/bpfm_ctrl.sv]
// Command sequencer of the buffer pool frame manager: scan wait, decision,
// frame walk, result word register and use counter. Depends on bpfm_pkg.
module bpfm_ctrl
   import bpfm_pkg::*;
#(
   parameter int NUM_FRAMES = DEF_NUM_FRAMES,
   parameter int STAMP_BITS = DEF_STAMP_BITS,
   parameter int PIN_BITS   = DEF_PIN_BITS,
   localparam int IDX_W     = $clog2(NUM_FRAMES)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  req_word_type                        req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rsp_word_type                        rsp_word,
   output logic [15:0]                         look_table,
   output logic [31:0]                         look_page,
   input  carry_type                           carry,
   input  logic [IDX_W-1:0]                    found_idx,
   input  logic [IDX_W-1:0]                    free_idx,
   input  logic [IDX_W-1:0]                    vic_idx,
   output op_type                              op,
   output logic [IDX_W-1:0]                    op_idx,
   output logic                                op_dflag,
   output logic [STAMP_BITS-1:0]               op_stamp,
   input  logic [NUM_FRAMES-1:0]               valid_v,
   input  logic [NUM_FRAMES-1:0]               dirty_v,
   input  logic [NUM_FRAMES-1:0][PIN_BITS-1:0] pins_v,
   input  logic [NUM_FRAMES-1:0][15:0]         table_v,
   input  logic [NUM_FRAMES-1:0][31:0]         page_v
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);

   state_type             state_ff, state_in;
   req_word_type          cmd_ff, cmd_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      tgt_ff, tgt_in;
   logic [1:0]            sts_ff, sts_in;
   logic [IDX_W-1:0]      sidx_ff, sidx_in;
   logic [STAMP_BITS-1:0] counter_ff, counter_in;
   rsp_word_type          rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  can_emit, accept, touch;
   logic                  walk_wb, walk_hit;

   function automatic logic [3:0] fidx(input logic [IDX_W-1:0] i);
      logic [IDX_W+3:0] e;
      e = {4'b0, i};
      return e[3:0];
   endfunction

   assign can_emit = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      tgt_in       = tgt_ff;
      sts_in       = sts_ff;
      sidx_in      = sidx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      op           = OP_NONE;
      op_idx       = tgt_ff;
      touch        = 1'b0;
      req_stall    = (state_ff != ST_IDLE);
      walk_hit     = valid_v[cnt_ff] &&
                     ((cmd_ff.cmd == CMD_FLALL) || (table_v[cnt_ff] == cmd_ff.table_id));
      walk_wb      = walk_hit && dirty_v[cnt_ff];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_word;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            sts_in   = STS_OK;
            sidx_in  = '0;
            state_in = ST_STAT;
            tgt_in   = found_idx;
            case (cmd_ff.cmd)
               CMD_FETCH: begin
                  if (carry.found) begin
                     op      = OP_HIT;
                     op_idx  = found_idx;
                     touch   = 1'b1;
                     sidx_in = found_idx;
                  end else if (carry.free_found || carry.vic_found) begin
                     tgt_in   = carry.free_found ? free_idx : vic_idx;
                     state_in = (carry.free_found || !dirty_v[vic_idx]) ? ST_RD : ST_WB;
                  end else begin
                     sts_in = STS_NOFREE;
                  end
               end
               CMD_UNPIN: begin
                  if (!carry.found) begin
                     sts_in = STS_NOTFOUND;
                  end else if (pins_v[found_idx] == '0) begin
                     sts_in  = STS_PINZERO;
                     sidx_in = found_idx;
                  end else begin
                     op      = OP_UNPIN;
                     op_idx  = found_idx;
                     touch   = 1'b1;
                     sidx_in = found_idx;
                  end
               end
               CMD_DIRTY: begin
                  if (!carry.found) begin
                     sts_in = STS_NOTFOUND;
                  end else begin
                     op      = OP_DIRTY;
                     op_idx  = found_idx;
                     touch   = 1'b1;
                     sidx_in = found_idx;
                  end
               end
               CMD_FLUSH: begin
                  if (carry.found) begin
                     sidx_in = found_idx;
                     if (dirty_v[found_idx]) state_in = ST_WB;
                  end
               end
               CMD_INVAL, CMD_FLALL: state_in = ST_WALK;
               default: ;
            endcase
         end
         ST_WB: begin
            if (can_emit) begin
               rsp_valid_in       = 1'b1;
               rsp_in.kind        = KIND_WB;
               rsp_in.status      = STS_OK;
               rsp_in.frame_no    = fidx(tgt_ff);
               rsp_in.io_table_id = table_v[tgt_ff];
               rsp_in.io_page_id  = page_v[tgt_ff];
               rsp_in.last        = 1'b0;
               op                 = OP_CLEAN;
               state_in           = (cmd_ff.cmd == CMD_FETCH) ? ST_RD : ST_STAT;
            end
         end
         ST_RD: begin
            if (can_emit) begin
               rsp_valid_in       = 1'b1;
               rsp_in.kind        = KIND_READ;
               rsp_in.status      = STS_OK;
               rsp_in.frame_no    = fidx(tgt_ff);
               rsp_in.io_table_id = cmd_ff.table_id;
               rsp_in.io_page_id  = cmd_ff.page_id;
               rsp_in.last        = 1'b0;
               op                 = OP_INSTALL;
               touch              = 1'b1;
               sts_in             = STS_OK;
               sidx_in            = tgt_ff;
               state_in           = ST_STAT;
            end
         end
         ST_WALK: begin
            op_idx = cnt_ff;
            if (!walk_wb || can_emit) begin
               if (walk_wb) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.kind        = KIND_WB;
                  rsp_in.status      = STS_OK;
                  rsp_in.frame_no    = fidx(cnt_ff);
                  rsp_in.io_table_id = table_v[cnt_ff];
                  rsp_in.io_page_id  = page_v[cnt_ff];
                  rsp_in.last        = 1'b0;
               end
               if (walk_hit) op = (cmd_ff.cmd == CMD_INVAL) ? OP_INVAL : OP_CLEAN;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  cnt_in   = '0;
                  state_in = ST_STAT;
               end
            end
         end
         ST_STAT: begin
            if (can_emit) begin
               rsp_valid_in       = 1'b1;
               rsp_in.kind        = KIND_STATUS;
               rsp_in.status      = sts_ff;
               rsp_in.frame_no    = fidx(sidx_ff);
               rsp_in.io_table_id = '0;
               rsp_in.io_page_id  = '0;
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      counter_in = touch ? counter_ff + 1'b1 : counter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         counter_ff   <= STAMP_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      tgt_ff  <= tgt_in;
      sts_ff  <= sts_in;
      sidx_ff <= sidx_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;
   assign look_table = cmd_ff.table_id;
   assign look_page  = cmd_ff.page_id;
   assign op_dflag   = cmd_ff.dirty_flag;
   assign op_stamp   = counter_ff;

`ifndef SYNTHESIS
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("accepted word did not start a scan");
   a_stat_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STAT) && can_emit |=> rsp_valid_ff && rsp_ff.last)
      else $error("final status word not issued");
   a_op_phase: assert property (@(posedge clock) disable iff (reset)
      (op != OP_NONE) |-> (state_ff != ST_IDLE) && (state_ff != ST_SCAN))
      else $error("frame update outside a command");
   a_found_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && carry.found |-> valid_v[found_idx])
      else $error("lookup hit on an invalid frame");
`endif

endmodule

[design/buffer_pool_frame_manager.sv]
// Buffer pool frame manager top level: a row of frame cells and the
// command sequencer. Depends on bpfm_pkg, bpfm_cell and bpfm_ctrl.
//
// Usage: one command word enters on req_ (valid/stall); the block stalls
// req_ until the command's last result word has been loaded into the
// output register. Each command yields zero or more write-back/read
// request words and then one status word with last set, on rsp_.
// Lookup and victim search run as a carry that passes one frame cell per
// clock, so each command waits in the scan state until the carry has
// passed every cell, then takes a decision state. A fetch miss then
// sends its request words; invalidate table and flush all walk every
// frame, one per cycle unless a write-back word has to wait on rsp_.
// A stalled rsp_ holds its word; the block waits only when a new word
// has to be loaded. The next command is taken while the last status word
// still waits. Reset clears every frame, sets the use counter to one and
// drops rsp_valid; no clearing pass is needed.
module buffer_pool_frame_manager
   import bpfm_pkg::*;
#(
   parameter int NUM_FRAMES = DEF_NUM_FRAMES,
   parameter int STAMP_BITS = DEF_STAMP_BITS,
   parameter int PIN_BITS   = DEF_PIN_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int IDX_W = $clog2(NUM_FRAMES);

   carry_type                           carry_c [NUM_FRAMES+1];
   logic [IDX_W-1:0]                    found_c [NUM_FRAMES+1];
   logic [IDX_W-1:0]                    free_c  [NUM_FRAMES+1];
   logic [IDX_W-1:0]                    vic_c   [NUM_FRAMES+1];
   logic [STAMP_BITS-1:0]               stamp_c [NUM_FRAMES+1];
   logic [NUM_FRAMES-1:0]               valid_v;
   logic [NUM_FRAMES-1:0]               dirty_v;
   logic [NUM_FRAMES-1:0][PIN_BITS-1:0] pins_v;
   logic [NUM_FRAMES-1:0][15:0]         table_v;
   logic [NUM_FRAMES-1:0][31:0]         page_v;
   logic [15:0]                         look_table;
   logic [31:0]                         look_page;
   op_type                              op;
   logic [IDX_W-1:0]                    op_idx;
   logic                                op_dflag;
   logic [STAMP_BITS-1:0]               op_stamp;

   assign carry_c[0] = '0;
   assign found_c[0] = '0;
   assign free_c[0]  = '0;
   assign vic_c[0]   = '0;
   assign stamp_c[0] = '0;

   for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
      bpfm_cell #(
         .NUM_FRAMES (NUM_FRAMES),
         .STAMP_BITS (STAMP_BITS),
         .PIN_BITS   (PIN_BITS),
         .CELL_IDX   (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .look_table  (look_table),
         .look_page   (look_page),
         .carry_i     (carry_c[g]),
         .found_idx_i (found_c[g]),
         .free_idx_i  (free_c[g]),
         .vic_idx_i   (vic_c[g]),
         .vic_stamp_i (stamp_c[g]),
         .carry_o     (carry_c[g+1]),
         .found_idx_o (found_c[g+1]),
         .free_idx_o  (free_c[g+1]),
         .vic_idx_o   (vic_c[g+1]),
         .vic_stamp_o (stamp_c[g+1]),
         .op          (op),
         .op_idx      (op_idx),
         .op_dflag    (op_dflag),
         .op_stamp    (op_stamp),
         .valid_o     (valid_v[g]),
         .dirty_o     (dirty_v[g]),
         .pins_o      (pins_v[g]),
         .table_o     (table_v[g]),
         .page_o      (page_v[g])
      );
   end

   bpfm_ctrl #(
      .NUM_FRAMES (NUM_FRAMES),
      .STAMP_BITS (STAMP_BITS),
      .PIN_BITS   (PIN_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .look_table (look_table),
      .look_page  (look_page),
      .carry      (carry_c[NUM_FRAMES]),
      .found_idx  (found_c[NUM_FRAMES]),
      .free_idx   (free_c[NUM_FRAMES]),
      .vic_idx    (vic_c[NUM_FRAMES]),
      .op         (op),
      .op_idx     (op_idx),
      .op_dflag   (op_dflag),
      .op_stamp   (op_stamp),
      .valid_v    (valid_v),
      .dirty_v    (dirty_v),
      .pins_v     (pins_v),
      .table_v    (table_v),
      .page_v     (page_v)
   );

endmodule
